@@ sv/pfa_pkg.sv @@
package pfa_pkg;

  // default sizes
  localparam int FrameCountDef = 4096;
  localparam int CountBitsDef  = 16;

  // fixed field widths
  localparam int KindW   = 2;
  localparam int IdxW    = 12;
  localparam int StatusW = 3;
  localparam int NcountW = 16;
  localparam int LinkW   = IdxW + 1;  // successor-exists flag on top of the index

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_INC   = 2'd2,
    KIND_DEC   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NONE_FREE = 3'd1,
    ST_IN_USE    = 3'd2,
    ST_ALREADY   = 3'd3,
    ST_CNT_ZERO  = 3'd4,
    ST_CNT_OVF   = 3'd5
  } status_e;

endpackage

@@ sv/pfa_ram.sv @@
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/page_frame_allocator_refcount.sv @@
// page frame allocator with per-frame reference counts
//
// input channel (in_valid_i / in_ready_o) carries one request word: kind_i
// selects allocate, free, increment or decrement, frame_index_i names the
// frame for all but allocate, zero_request_i is echoed on a good allocate.
// output channel (out_valid_o / out_ready_i) returns one result word per
// request: status, granted frame, clear-page flag, new count, released flag.
//
// all per-frame state (on-list bit, count, free-list link) lives in one
// synchronous ram word. a request is read in the accept cycle and the word is
// modified and written back in the execute state once the output register
// is free; no new request is taken until that write-back is done. the ram
// read latency and the head-link dependency between pops require this.
//
// after reset the block sweeps the ram to zero, one entry a cycle, over all
// min(FRAME_COUNT, 4096) entries; in_ready_o stays low during the sweep.
// the result sits in an output register; while the receiver stalls the next
// request is still accepted and read, and its write-back waits until the
// output register is taken.
module page_frame_allocator_refcount #(
  parameter int FRAME_COUNT = pfa_pkg::FrameCountDef,
  parameter int COUNT_BITS  = pfa_pkg::CountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pfa_pkg::KindW-1:0]   kind_i,
  input  logic [pfa_pkg::IdxW-1:0]    frame_index_i,
  input  logic                        zero_request_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pfa_pkg::StatusW-1:0] status_o,
  output logic [pfa_pkg::IdxW-1:0]    granted_frame_o,
  output logic                        clear_page_o,
  output logic [pfa_pkg::NcountW-1:0] new_count_o,
  output logic                        released_o
);

  localparam int IdxW   = pfa_pkg::IdxW;
  localparam int LinkW  = pfa_pkg::LinkW;
  // frame numbers are 12 bits wide, so no more than 4096 entries can be reached
  localparam int Depth  = (FRAME_COUNT < (1 << IdxW)) ? FRAME_COUNT : (1 << IdxW);
  localparam int Aw     = $clog2(Depth);
  localparam int WordW  = 1 + COUNT_BITS + LinkW;

  // ram word layout: {on_list, count, link}
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [Aw-1:0] clr_q, clr_d;

  logic [IdxW-1:0] head_q, head_d;
  logic            nonempty_q, nonempty_d;

  // captured request
  pfa_pkg::kind_e  kind_q;
  logic [IdxW-1:0] frame_q;
  logic            zreq_q;

  // output register
  logic                        out_valid_q;
  pfa_pkg::status_e            status_q;
  logic [IdxW-1:0]             granted_q;
  logic                        clear_q;
  logic [pfa_pkg::NcountW-1:0] ncount_q;
  logic                        rel_q;

  // ram ports
  logic             ram_we, ram_re;
  logic [Aw-1:0]    ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  // execute-stage signals
  logic                  rd_on;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [LinkW-1:0]      rd_link;
  logic                  in_range;
  logic                  accept, fire;
  logic                  exec_we;
  logic [Aw-1:0]         exec_waddr;
  logic [WordW-1:0]      exec_wdata;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [31:0]           cnt_wide;
  logic [LinkW-1:0]      push_link;
  pfa_pkg::status_e      st_c;
  logic [IdxW-1:0]       granted_c;
  logic                  clear_c;
  logic                  rel_c;
  logic [IdxW-1:0]       ehead_d;
  logic                  enonempty_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign rd_on   = ram_rdata[WordW-1];
  assign rd_cnt  = ram_rdata[LinkW +: COUNT_BITS];
  assign rd_link = ram_rdata[LinkW-1:0];

  assign in_range  = 32'(frame_q) < 32'(FRAME_COUNT);
  // link written into a frame being pushed: points at the old head if any
  assign push_link = nonempty_q ? {1'b1, head_q} : '0;
  assign cnt_wide  = 32'(cnt_new);

  // modify step of the read-modify-write
  always_comb begin
    st_c        = pfa_pkg::ST_OK;
    granted_c   = '0;
    clear_c     = 1'b0;
    rel_c       = 1'b0;
    cnt_new     = '0;
    exec_we     = 1'b0;
    exec_waddr  = frame_q[Aw-1:0];
    exec_wdata  = ram_rdata;
    ehead_d     = head_q;
    enonempty_d = nonempty_q;
    if (kind_q == pfa_pkg::KIND_ALLOC) begin
      if (!nonempty_q) begin
        st_c = pfa_pkg::ST_NONE_FREE;
      end else begin
        // pop: clear the on-list bit, follow the link
        exec_we    = 1'b1;
        exec_waddr = head_q[Aw-1:0];
        exec_wdata = {1'b0, rd_cnt, rd_link};
        if (rd_link[LinkW-1]) begin
          ehead_d = rd_link[IdxW-1:0];
        end else begin
          ehead_d     = '0;
          enonempty_d = 1'b0;
        end
        granted_c = head_q;
        clear_c   = zreq_q;
        cnt_new   = rd_cnt;
      end
    end else if (!in_range) begin
      case (kind_q)
        pfa_pkg::KIND_FREE: st_c = pfa_pkg::ST_ALREADY;
        pfa_pkg::KIND_INC:  st_c = pfa_pkg::ST_CNT_OVF;
        default:            st_c = pfa_pkg::ST_CNT_ZERO;
      endcase
    end else begin
      case (kind_q)
        pfa_pkg::KIND_FREE: begin
          cnt_new = rd_cnt;
          if (rd_cnt != '0) begin
            st_c = pfa_pkg::ST_IN_USE;
          end else if (rd_on) begin
            st_c = pfa_pkg::ST_ALREADY;
          end else begin
            exec_we     = 1'b1;
            exec_wdata  = {1'b1, rd_cnt, push_link};
            ehead_d     = frame_q;
            enonempty_d = 1'b1;
          end
        end
        pfa_pkg::KIND_INC: begin
          if (rd_cnt == {COUNT_BITS{1'b1}}) begin
            st_c    = pfa_pkg::ST_CNT_OVF;
            cnt_new = rd_cnt;
          end else begin
            cnt_new    = rd_cnt + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            exec_we    = 1'b1;
            exec_wdata = {rd_on, cnt_new, rd_link};
          end
        end
        default: begin
          if (rd_cnt == '0) begin
            st_c = pfa_pkg::ST_CNT_ZERO;
          end else if (rd_cnt == {{(COUNT_BITS-1){1'b0}}, 1'b1}) begin
            if (rd_on) begin
              // last reference of a frame still listed: refused
              st_c    = pfa_pkg::ST_ALREADY;
              cnt_new = rd_cnt;
            end else begin
              // count reaches zero: push the frame back
              exec_we     = 1'b1;
              exec_wdata  = {1'b1, {COUNT_BITS{1'b0}}, push_link};
              ehead_d     = frame_q;
              enonempty_d = 1'b1;
              rel_c       = 1'b1;
            end
          end else begin
            cnt_new    = rd_cnt - {{(COUNT_BITS-1){1'b0}}, 1'b1};
            exec_we    = 1'b1;
            exec_wdata = {rd_on, cnt_new, rd_link};
          end
        end
      endcase
    end
  end

  // sequencer and ram port selection
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    head_d     = head_q;
    nonempty_d = nonempty_q;
    ram_we     = 1'b0;
    ram_waddr  = exec_waddr;
    ram_wdata  = exec_wdata;
    ram_re     = 1'b0;
    ram_raddr  = (pfa_pkg::kind_e'(kind_i) == pfa_pkg::KIND_ALLOC) ?
                 head_q[Aw-1:0] : frame_index_i[Aw-1:0];
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + {{(Aw-1){1'b0}}, 1'b1};
        if (clr_q == Aw'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ram_re  = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          ram_we     = exec_we;
          head_d     = ehead_d;
          nonempty_d = enonempty_d;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= pfa_pkg::kind_e'(kind_i);
      frame_q <= frame_index_i;
      zreq_q  <= zero_request_i;
    end
    if (fire) begin
      status_q  <= st_c;
      granted_q <= granted_c;
      clear_q   <= clear_c;
      ncount_q  <= cnt_wide[pfa_pkg::NcountW-1:0];
      rel_q     <= rel_c;
    end
  end

  pfa_ram #(
    .WIDTH (WordW),
    .DEPTH (Depth)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_frame_o = granted_q;
  assign clear_page_o    = clear_q;
  assign new_count_o     = ncount_q;
  assign released_o      = rel_q;

endmodule

@@ sim/page_frame_monitor.sv @@
`timescale 1ns / 1ps
module page_frame_monitor
  import pfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [KindW-1:0]   kind_i,
  input  logic [IdxW-1:0]    frame_index_i,
  input  logic               zero_request_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [IdxW-1:0]    granted_frame_i,
  input  logic               clear_page_i,
  input  logic [NcountW-1:0] new_count_i,
  input  logic               released_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int FrameCnt = FrameCountDef;
  localparam int CountW   = CountBitsDef;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    status_e             status;
    logic [IdxW-1:0]     granted;
    logic                clear;
    logic [NcountW-1:0]  count;
    logic                released;
  } answer_t;

  // shadow of the free list and the per-frame counts
  logic [IdxW-1:0]   list_top;
  logic              list_full;
  logic [LinkW-1:0]  succ_link [FrameCnt];
  logic              listed    [FrameCnt];
  logic [CountW-1:0] ref_cnt   [FrameCnt];
  answer_t           answers_q [$];

  function automatic void push_free_frame(int f);
    succ_link[f] = list_full ? {1'b1, list_top} : '0;
    list_top     = f[IdxW-1:0];
    list_full    = 1'b1;
    listed[f]    = 1'b1;
  endfunction

  function automatic answer_t serve_request(kind_e k, logic [IdxW-1:0] f, logic z);
    answer_t a;
    int      fi;
    a  = '0;
    fi = int'(f);
    if (k != KIND_ALLOC && fi >= FrameCnt) begin
      a.status = (k == KIND_FREE) ? ST_ALREADY : (k == KIND_INC) ? ST_CNT_OVF : ST_CNT_ZERO;
    end else begin
      case (k)
        KIND_ALLOC: begin
          if (!list_full) begin
            a.status = ST_NONE_FREE;
          end else begin
            fi         = int'(list_top);
            listed[fi] = 1'b0;
            if (succ_link[fi][IdxW]) begin
              list_top = succ_link[fi][IdxW-1:0];
            end else begin
              list_top  = '0;
              list_full = 1'b0;
            end
            a.granted = fi[IdxW-1:0];
            a.clear   = z;
            a.count   = ref_cnt[fi];
          end
        end
        KIND_FREE: begin
          a.count = ref_cnt[fi];
          if (ref_cnt[fi] != '0) begin
            a.status = ST_IN_USE;
          end else if (listed[fi]) begin
            a.status = ST_ALREADY;
          end else begin
            push_free_frame(fi);
          end
        end
        KIND_INC: begin
          if (ref_cnt[fi] == CountMax) begin
            a.status = ST_CNT_OVF;
          end else begin
            ref_cnt[fi] = ref_cnt[fi] + 1'b1;
          end
          a.count = ref_cnt[fi];
        end
        default: begin
          if (ref_cnt[fi] == '0) begin
            a.status = ST_CNT_ZERO;
          end else if (ref_cnt[fi] == 1) begin
            if (listed[fi]) begin
              a.status = ST_ALREADY;
            end else begin
              ref_cnt[fi] = '0;
              push_free_frame(fi);
              a.released = 1'b1;
            end
          end else begin
            ref_cnt[fi] = ref_cnt[fi] - 1'b1;
          end
          a.count = ref_cnt[fi];
        end
      endcase
    end
    return a;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      list_top  = '0;
      list_full = 1'b0;
      for (int i = 0; i < FrameCnt; i++) begin
        succ_link[i] = '0;
        listed[i]    = 1'b0;
        ref_cnt[i]   = '0;
      end
      answers_q.delete();
      pending_o = 0;
    end else begin
      // compare before predicting: a word taken this edge cannot answer itself
      if (out_valid_i && out_ready_i) begin
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual status %0d",
                   $time, status_i);
          fail_count_o++;
        end else begin
          want = answers_q.pop_front();
          check_field("status", want.status, status_i);
          check_field("granted_frame", want.granted, granted_frame_i);
          check_field("clear_page", want.clear, clear_page_i);
          check_field("new_count", want.count, new_count_i);
          check_field("released", want.released, released_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        answers_q.push_back(serve_request(kind_e'(kind_i), frame_index_i, zero_request_i));
      end
      pending_o = answers_q.size();
    end
  end

endmodule

@@ sim/page_frame_allocator_refcount_tb.sv @@
`timescale 1ns / 1ps
module page_frame_allocator_refcount_tb;
  import pfa_pkg::*;

  localparam int PoolSize = 24;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [KindW-1:0]   kind_i;
  logic [IdxW-1:0]    frame_index_i;
  logic               zero_request_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [StatusW-1:0] status_o;
  logic [IdxW-1:0]    granted_frame_o;
  logic               clear_page_o;
  logic [NcountW-1:0] new_count_o;
  logic               released_o;

  // idle percentages per side, changed by phase
  int tx_idle_pct;
  int rx_idle_pct;
  // request for one long receiver hold-off, raised once by the stimulus
  bit stall_req;
  int words_sent;
  int fail_count;
  int pending;

  // small set of frames so requests keep hitting the same entries
  logic [IdxW-1:0] frame_pool [PoolSize];

  page_frame_allocator_refcount dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .frame_index_i  (frame_index_i),
    .zero_request_i (zero_request_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .granted_frame_o(granted_frame_o),
    .clear_page_o   (clear_page_o),
    .new_count_o    (new_count_o),
    .released_o     (released_o)
  );

  page_frame_monitor monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .frame_index_i  (frame_index_i),
    .zero_request_i (zero_request_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .granted_frame_i(granted_frame_o),
    .clear_page_i   (clear_page_o),
    .new_count_i    (new_count_o),
    .released_i     (released_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop; the slowest legal run is far shorter
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int held;
    bit stall_done;
    out_ready_i = 1'b0;
    stall_done  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req && !stall_done) begin
        stall_done = 1'b1;
        out_ready_i <= 1'b0;
        for (held = 0; held < 300; held++) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // offer one request word; returns at the edge where it is taken
  task automatic send_word(input kind_e k, input logic [IdxW-1:0] f, input logic z);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    frame_index_i  <= f;
    zero_request_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // drop valid and hold off until every outstanding result is back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [IdxW-1:0] pick_frame();
    if ($urandom_range(0, 99) < 85) begin
      return frame_pool[$urandom_range(0, PoolSize - 1)];
    end
    return IdxW'($urandom_range(0, 4095));
  endfunction

  initial begin
    logic [IdxW-1:0] f;
    int              phase_start;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_ALLOC;
    frame_index_i  = '0;
    zero_request_i = 1'b0;
    stall_req      = 1'b0;
    words_sent     = 0;
    tx_idle_pct    = 38;
    rx_idle_pct    = 70;
    frame_pool[0]  = '0;
    frame_pool[1]  = '1;
    for (int i = 2; i < PoolSize; i++) frame_pool[i] = IdxW'($urandom_range(1, 4094));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: error paths first, then list order and release
    send_word(KIND_ALLOC, '0, 1'b1);     // empty list
    send_word(KIND_DEC, 12'd5, 1'b0);    // decrement at zero
    send_word(KIND_FREE, 12'd5, 1'b1);   // push, zero request ignored
    send_word(KIND_FREE, 12'd5, 1'b0);   // already listed
    send_word(KIND_INC, 12'd5, 1'b1);    // increment while listed is legal
    send_word(KIND_DEC, 12'd5, 1'b0);    // count one but listed, nothing moves
    send_word(KIND_FREE, 12'd5, 1'b0);   // count test wins over list test
    send_word(KIND_FREE, '1, 1'b0);
    send_word(KIND_FREE, '0, 1'b0);
    send_word(KIND_ALLOC, '1, 1'b1);     // lifo: frame 0 comes back first
    send_word(KIND_ALLOC, '0, 1'b0);     // then the top frame
    send_word(KIND_ALLOC, '1, 1'b1);     // then frame 5, count still one
    send_word(KIND_ALLOC, '0, 1'b0);     // empty again
    send_word(KIND_DEC, 12'd5, 1'b0);    // released back onto the list
    send_word(KIND_INC, '1, 1'b0);
    send_word(KIND_INC, '1, 1'b1);
    send_word(KIND_DEC, '1, 1'b0);
    send_word(KIND_DEC, '1, 1'b1);       // released
    send_word(KIND_ALLOC, '0, 1'b1);
    send_word(KIND_ALLOC, '0, 1'b0);

    // sender waits for the last result, then the receiver blocks for a while
    // and the sender keeps pushing until the block backs up
    drain_results();
    stall_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_word(kind_e'($urandom_range(0, 3)), pick_frame(), 1'($urandom_range(0, 1)));
    end

    // random words over three idle settings
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 70 : 0;
      rx_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 38 : 0;
      phase_start = words_sent;
      while (words_sent - phase_start < 550) begin
        if ($urandom_range(0, 3) == 0) begin
          // full life of one frame: free, take it, share it, drop both refs
          f = pick_frame();
          send_word(KIND_FREE, f, 1'($urandom_range(0, 1)));
          send_word(KIND_ALLOC, pick_frame(), 1'($urandom_range(0, 1)));
          send_word(KIND_INC, f, 1'($urandom_range(0, 1)));
          send_word(KIND_INC, f, 1'($urandom_range(0, 1)));
          send_word(KIND_DEC, f, 1'($urandom_range(0, 1)));
          send_word(KIND_DEC, f, 1'($urandom_range(0, 1)));
        end else begin
          send_word(kind_e'($urandom_range(0, 3)), pick_frame(), 1'($urandom_range(0, 1)));
        end
      end
    end

    drain_results();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
